// ----- src/xorshift128_ranged_random_defines.svh -----
// Assertion macros for the xorshift128 ranged random generator checker.
`ifndef XORSHIFT128_RANGED_RANDOM_DEFINES_SVH
`define XORSHIFT128_RANGED_RANDOM_DEFINES_SVH

// Check a consequent in the same cycle as its antecedent.
`define XRR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("xrr assertion failed");

// Check a consequent in the cycle after its antecedent.
`define XRR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("xrr assertion failed");

`endif

// ----- src/xrr_pkg.sv -----
// Types and constants shared by the xorshift128 ranged random generator.
`default_nettype none

package xrr_pkg;

  localparam int unsigned WORD_W      = 32;
  localparam int unsigned VALUE_W     = 33;
  localparam int unsigned CNT_W       = 5;
  localparam int unsigned NUM_WORDS   = 4;
  localparam int unsigned IN_TDATA_W  = 72;
  localparam int unsigned OUT_TDATA_W = 40;
  localparam int unsigned OUT_PAD_W   = OUT_TDATA_W - VALUE_W;

  localparam int unsigned SHIFT_A = 15;
  localparam int unsigned SHIFT_B = 4;
  localparam int unsigned SHIFT_C = 21;

  localparam logic [WORD_W-1:0] SEED_MULT     = 32'd1812433253;
  localparam logic [1:0]        SEED_LAST_IDX = 2'd2;

  typedef enum logic [1:0] {
    ACT_RAW     = 2'd0,
    ACT_BELOW   = 2'd1,
    ACT_BETWEEN = 2'd2
  } xrr_action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED_GO,
    ST_SEED_WAIT,
    ST_PREP,
    ST_REM,
    ST_DONE
  } xrr_state_e;

  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] operand_a;
    logic [WORD_W-1:0] operand_b;
  } xrr_unit_req_t;

  typedef struct packed {
    logic done;
  } xrr_unit_sts_t;

endpackage

`default_nettype wire

// ----- src/xrr_mul.sv -----
// Bit-serial shift-add multiplier, product modulo 2^32, one multiplier bit per cycle.
`default_nettype none

module xrr_mul
  import xrr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  xrr_unit_req_t     req_i,
  output xrr_unit_sts_t     sts_o,
  output logic [WORD_W-1:0] prod_o
);

  logic [WORD_W-1:0] acc_q, acc_d;
  logic [WORD_W-1:0] mcand_q, mcand_d;
  logic [WORD_W-1:0] mplier_q, mplier_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;

  always_comb begin
    acc_d    = acc_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    cnt_d    = cnt_q;
    busy_d   = busy_q;
    done_d   = 1'b0;
    if (req_i.start) begin
      acc_d    = '0;
      mcand_d  = req_i.operand_a;
      mplier_d = req_i.operand_b;
      cnt_d    = '0;
      busy_d   = 1'b1;
    end else if (busy_q) begin
      if (mplier_q[0]) begin
        acc_d = acc_q + mcand_q;
      end
      mcand_d  = {mcand_q[WORD_W-2:0], 1'b0};
      mplier_d = {1'b0, mplier_q[WORD_W-1:1]};
      cnt_d    = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(WORD_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
  end

  assign sts_o.done = done_q;
  assign prod_o     = acc_q;

endmodule

`default_nettype wire

// ----- src/xrr_rem.sv -----
// Radix-2 restoring remainder unit, one dividend bit per cycle.
`default_nettype none

module xrr_rem
  import xrr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  xrr_unit_req_t     req_i,
  output xrr_unit_sts_t     sts_o,
  output logic [WORD_W-1:0] rem_o
);

  logic [WORD_W-1:0] rem_q, rem_d;
  logic [WORD_W-1:0] dvd_q, dvd_d;
  logic [WORD_W-1:0] dvs_q, dvs_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [WORD_W:0]   trial;
  logic [WORD_W:0]   diff;

  assign trial = {rem_q, dvd_q[WORD_W-1]};
  assign diff  = trial - {1'b0, dvs_q};

  always_comb begin
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d  = '0;
      dvd_d  = req_i.operand_a;
      dvs_d  = req_i.operand_b;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      // keep the shifted remainder when the trial subtract goes negative
      rem_d = diff[WORD_W] ? trial[WORD_W-1:0] : diff[WORD_W-1:0];
      dvd_d = {dvd_q[WORD_W-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(WORD_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
  end

  assign sts_o.done = done_q;
  assign rem_o      = rem_q;

endmodule

`default_nettype wire

// ----- src/xorshift128_ranged_random.sv -----
// Top level of the xorshift128 ranged random generator.
// An accepted item passes through ST_PREP and, for a bounded draw, the bit-serial remainder
// unit in ST_REM, then ST_DONE; a raw word or a request that does not draw skips ST_REM.
// A new item is accepted only after the previous one has left ST_DONE, so items never overlap.
// Reset loads the generator words with 0, 1, 2, 3. A seed write reloads them through the
// bit-serial multiplier, during which no item is accepted.
`default_nettype none

module xorshift128_ranged_random
  import xrr_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [WORD_W-1:0]      cfg_data_i,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // action[1:0], low_bound[33:2], high_bound[65:34], zero pad[71:66]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // value[32:0], zero pad[39:33]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  xrr_state_e        state_q, state_d;
  logic [WORD_W-1:0] words_q [NUM_WORDS];
  logic [WORD_W-1:0] words_d [NUM_WORDS];
  logic [WORD_W-1:0] words_adv [NUM_WORDS];
  logic [1:0]        idx_q, idx_d;
  logic [1:0]        idx_nx;
  xrr_action_e       act_q, act_d;
  logic [WORD_W-1:0] lo_q, lo_d;
  logic [WORD_W-1:0] hi_q, hi_d;
  logic [WORD_W-1:0] base_q, base_d;
  logic [VALUE_W-1:0] res_q, res_d;
  logic              outv_q, outv_d;
  logic [VALUE_W-1:0] out_q, out_d;

  logic [WORD_W-1:0] mix_t;
  logic [WORD_W-1:0] draw_w;
  logic              swap;
  logic [WORD_W-1:0] lo_e;
  logic [WORD_W-1:0] hi_e;
  logic [WORD_W-1:0] span;
  logic              below_ok;
  logic [WORD_W-1:0] sum;

  xrr_unit_req_t     mul_req;
  xrr_unit_sts_t     mul_sts;
  logic [WORD_W-1:0] mul_prod;
  xrr_unit_req_t     rem_req;
  xrr_unit_sts_t     rem_sts;
  logic [WORD_W-1:0] rem_val;

  xrr_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .sts_o  (mul_sts),
    .prod_o (mul_prod)
  );

  xrr_rem u_rem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (rem_req),
    .sts_o  (rem_sts),
    .rem_o  (rem_val)
  );

  assign mix_t  = words_q[0] ^ (words_q[0] << SHIFT_A);
  assign draw_w = (words_q[3] ^ (words_q[3] >> SHIFT_C)) ^ (mix_t ^ (mix_t >> SHIFT_B));

  assign words_adv[0] = words_q[1];
  assign words_adv[1] = words_q[2];
  assign words_adv[2] = words_q[3];
  assign words_adv[3] = draw_w;

  assign swap     = $signed(lo_q) > $signed(hi_q);
  assign lo_e     = swap ? hi_q : lo_q;
  assign hi_e     = swap ? lo_q : hi_q;
  assign span     = hi_e - lo_e;
  assign below_ok = !hi_q[WORD_W-1] && (hi_q != '0);
  assign sum      = base_q + rem_val;
  assign idx_nx   = idx_q + 2'd1;

  always_comb begin
    state_d       = state_q;
    words_d       = words_q;
    idx_d         = idx_q;
    act_d         = act_q;
    lo_d          = lo_q;
    hi_d          = hi_q;
    base_d        = base_q;
    res_d         = res_q;
    out_d         = out_q;
    outv_d        = outv_q && !m_axis_tready;
    mul_req       = '0;
    rem_req       = '0;
    cfg_ready_o   = 1'b0;
    s_axis_tready = 1'b0;
    case (state_q)
      ST_IDLE: begin
        cfg_ready_o   = 1'b1;
        s_axis_tready = !cfg_valid_i;
        if (cfg_valid_i) begin
          words_d[0] = cfg_data_i;
          idx_d      = '0;
          state_d    = ST_SEED_GO;
        end else if (s_axis_tvalid) begin
          act_d   = xrr_action_e'(s_axis_tdata[1:0]);
          lo_d    = s_axis_tdata[33:2];
          hi_d    = s_axis_tdata[65:34];
          state_d = ST_PREP;
        end
      end
      ST_SEED_GO: begin
        mul_req.start     = 1'b1;
        mul_req.operand_a = (idx_q == '0) ? words_q[0] : mul_prod;
        mul_req.operand_b = SEED_MULT;
        state_d           = ST_SEED_WAIT;
      end
      ST_SEED_WAIT: begin
        if (mul_sts.done) begin
          words_d[idx_nx] = mul_prod + WORD_W'(idx_nx);
          if (idx_q == SEED_LAST_IDX) begin
            state_d = ST_IDLE;
          end else begin
            idx_d   = idx_nx;
            state_d = ST_SEED_GO;
          end
        end
      end
      ST_PREP: begin
        state_d = ST_DONE;
        res_d   = '0;
        case (act_q)
          ACT_RAW: begin
            words_d = words_adv;
            res_d   = {1'b0, draw_w};
          end
          ACT_BELOW: begin
            if (below_ok) begin
              words_d           = words_adv;
              rem_req.start     = 1'b1;
              rem_req.operand_a = draw_w;
              rem_req.operand_b = hi_q;
              base_d            = '0;
              state_d           = ST_REM;
            end
          end
          ACT_BETWEEN: begin
            if (lo_q == hi_q) begin
              res_d = {lo_q[WORD_W-1], lo_q};
            end else begin
              words_d           = words_adv;
              rem_req.start     = 1'b1;
              rem_req.operand_a = draw_w;
              rem_req.operand_b = span;
              base_d            = lo_e;
              state_d           = ST_REM;
            end
          end
          default: begin
            res_d = '0;
          end
        endcase
      end
      ST_REM: begin
        if (rem_sts.done) begin
          res_d   = {sum[WORD_W-1], sum};
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!outv_q || m_axis_tready) begin
          outv_d  = 1'b1;
          out_d   = res_q;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      outv_q  <= 1'b0;
      for (int i = 0; i < NUM_WORDS; i++) begin
        words_q[i] <= WORD_W'(i);
      end
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      outv_q  <= outv_d;
      words_q <= words_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q  <= act_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    base_q <= base_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  assign m_axis_tvalid = outv_q;
  assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_q};

endmodule

`default_nettype wire

// ----- src/xrr_checker.sv -----
// Port-level checker for the xorshift128 ranged random generator, bound to the top level.
`default_nettype none

`include "xorshift128_ranged_random_defines.svh"

module xrr_checker
  import xrr_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   cfg_valid_i,
  input logic                   cfg_ready_o,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  `XRR_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `XRR_ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
  `XRR_ASSERT_NEXT(a_busy_after_item, s_axis_tvalid && s_axis_tready, !s_axis_tready && !cfg_ready_o)
  `XRR_ASSERT_NEXT(a_busy_after_seed, cfg_valid_i && cfg_ready_o, !s_axis_tready && !cfg_ready_o)
  `XRR_ASSERT_NOW(a_no_input_on_seed, cfg_valid_i && cfg_ready_o, !s_axis_tready)

endmodule

bind xorshift128_ranged_random xrr_checker u_xrr_checker (.*);

`default_nettype wire

// ----- tb/xorshift128_ranged_random_test.sv -----
// Self-checking stream testbench for the xorshift128 ranged random generator.
module xorshift128_ranged_random_test;
  import xrr_pkg::*;

  localparam logic [1:0]        ACT_UNUSED     = 2'd3;
  localparam logic [WORD_W-1:0] INT_MIN        = 32'h8000_0000;
  localparam logic [WORD_W-1:0] INT_MAX        = 32'h7FFF_FFFF;
  localparam int                WATCHDOG_LIMIT = 1000;
  localparam int                DRAIN_CYCLES   = 40;
  localparam int                MAX_REPORTS    = 20;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_valid_i   = 1'b0;
  logic                   cfg_ready_o;
  logic [WORD_W-1:0]      cfg_data_i    = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // action[1:0], low_bound[33:2], high_bound[65:34], zero pad[71:66]
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b1;
  // value[32:0], zero pad[39:33]
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  logic [WORD_W-1:0]  gen_words [NUM_WORDS];
  logic [VALUE_W-1:0] pending_values [$];
  logic               no_idle         = 1'b0;
  int                 rx_wait         = 0;
  int                 idle_cycles     = 0;
  int                 err_count       = 0;
  int                 results_checked = 0;
  int                 seed_writes     = 0;
  int                 act_count [4]   = '{default: 0};

  xorshift128_ranged_random DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic void load_seed(input logic [WORD_W-1:0] seed_word);
    logic [WORD_W-1:0] power;
    power = seed_word;
    gen_words[0] = power;
    for (int i = 1; i < NUM_WORDS; i++) begin
      power = power * SEED_MULT;
      gen_words[i] = power + 32'(i);
    end
  endfunction

  function automatic logic [WORD_W-1:0] next_word();
    logic [WORD_W-1:0] mixed;
    logic [WORD_W-1:0] newest;
    mixed = gen_words[0] ^ (gen_words[0] << SHIFT_A);
    newest = gen_words[3];
    gen_words[0] = gen_words[1];
    gen_words[1] = gen_words[2];
    gen_words[2] = newest;
    newest = (newest ^ (newest >> SHIFT_C)) ^ (mixed ^ (mixed >> SHIFT_B));
    gen_words[3] = newest;
    return newest;
  endfunction

  function automatic logic [VALUE_W-1:0] predict_value(input logic [1:0] act,
                                                       input logic [WORD_W-1:0] lo,
                                                       input logic [WORD_W-1:0] hi);
    logic [WORD_W-1:0]  lower;
    logic [WORD_W-1:0]  upper;
    logic [WORD_W-1:0]  pick;
    logic [VALUE_W-1:0] value;
    value = '0;
    case (act)
      ACT_RAW: begin
        value = {1'b0, next_word()};
      end
      ACT_BELOW: begin
        if ($signed(hi) > 0) begin
          pick = next_word() % hi;
          value = {pick[WORD_W-1], pick};
        end
      end
      ACT_BETWEEN: begin
        if ($signed(lo) > $signed(hi)) begin
          lower = hi;
          upper = lo;
        end else begin
          lower = lo;
          upper = hi;
        end
        if (lower == upper) begin
          pick = lower;
        end else begin
          pick = lower + next_word() % (upper - lower);
        end
        value = {pick[WORD_W-1], pick};
      end
      default: begin
        value = '0;
      end
    endcase
    return value;
  endfunction

  // Predict on input accept, check on output accept, stall the receiver, watch for hangs.
  always @(posedge clk_i) begin
    logic [VALUE_W-1:0] want;
    logic               moved;
    moved = 1'b0;
    if (cfg_valid_i && cfg_ready_o) begin
      load_seed(cfg_data_i);
      seed_writes++;
      moved = 1'b1;
    end
    if (s_axis_tvalid && s_axis_tready) begin
      pending_values.push_back(predict_value(s_axis_tdata[1:0], s_axis_tdata[33:2],
                                             s_axis_tdata[65:34]));
      act_count[s_axis_tdata[1:0]]++;
      moved = 1'b1;
    end
    if (m_axis_tvalid && m_axis_tready) begin
      moved = 1'b1;
      results_checked++;
      if (pending_values.size() == 0) begin
        err_count++;
        if (err_count <= MAX_REPORTS) begin
          $display("%0t: unexpected item, expected none, actual value %h", $time,
                   m_axis_tdata[VALUE_W-1:0]);
        end
      end else begin
        want = pending_values.pop_front();
        if (m_axis_tdata[VALUE_W-1:0] !== want) begin
          err_count++;
          if (err_count <= MAX_REPORTS) begin
            $display("%0t: value mismatch, expected %h, actual %h", $time, want,
                     m_axis_tdata[VALUE_W-1:0]);
          end
        end
      end
      rx_wait = no_idle ? 0 : $urandom_range(0, 6);
      if (rx_wait != 0) begin
        m_axis_tready <= 1'b0;
      end
    end else if (rx_wait != 0) begin
      rx_wait--;
      if (rx_wait == 0) begin
        m_axis_tready <= 1'b1;
      end
    end
    idle_cycles = moved ? 0 : idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no item moved for %0d cycles, %0d results outstanding", $time,
               idle_cycles, pending_values.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_item(input logic [1:0] act, input logic [WORD_W-1:0] lo,
                           input logic [WORD_W-1:0] hi);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata  <= {{(IN_TDATA_W - 66){1'b0}}, hi, lo, act};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_values.size() != 0);
  endtask

  task automatic write_seed(input logic [WORD_W-1:0] seed_word);
    cfg_data_i  <= seed_word;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [WORD_W-1:0] pick_bound();
    case ($urandom_range(0, 9))
      0:       return INT_MIN;
      1:       return INT_MAX;
      2:       return '0;
      3:       return '1;
      4, 5, 6: return 32'($urandom_range(0, 200)) - 32'd100;
      default: return $urandom();
    endcase
  endfunction

  task automatic test_reset_state();
    send_item(ACT_RAW, INT_MIN, INT_MAX);
    send_item(ACT_BELOW, '0, 32'd1000);
    send_item(ACT_BETWEEN, -32'd5, 32'd5);
    wait_drained();
  endtask

  task automatic test_special_cases();
    send_item(ACT_BELOW, '1, '0);
    send_item(ACT_BELOW, INT_MAX, '1);
    send_item(ACT_BELOW, '0, INT_MIN);
    send_item(ACT_BELOW, '0, 32'd1);
    send_item(ACT_BELOW, INT_MIN, INT_MAX);
    send_item(ACT_BETWEEN, 32'd10, -32'd10);
    send_item(ACT_BETWEEN, 32'd5, 32'd5);
    send_item(ACT_BETWEEN, INT_MIN, INT_MIN);
    send_item(ACT_BETWEEN, INT_MIN, INT_MAX);
    send_item(ACT_BETWEEN, INT_MAX, INT_MIN);
    send_item(ACT_BETWEEN, '1, '0);
    send_item(ACT_UNUSED, INT_MAX, INT_MAX);
    send_item(ACT_RAW, '1, '1);
    wait_drained();
  endtask

  task automatic test_seed_extremes();
    logic [WORD_W-1:0] seeds [4];
    seeds = '{32'd0, 32'd1, INT_MIN, 32'hFFFF_FFFF};
    foreach (seeds[i]) begin
      write_seed(seeds[i]);
      send_item(ACT_RAW, '0, '0);
      send_item(ACT_BETWEEN, INT_MIN, INT_MAX);
      wait_drained();
    end
  endtask

  task automatic test_random_traffic(input int n_items);
    logic [1:0]        act;
    logic [WORD_W-1:0] lo;
    logic [WORD_W-1:0] hi;
    int                pick;
    for (int i = 0; i < n_items; i++) begin
      if (i % 25 == 0) begin
        no_idle = ($urandom_range(0, 3) == 0);
      end
      if (i == n_items / 2 || $urandom_range(0, 59) == 0) begin
        wait_drained();
      end
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        act = ACT_RAW;
      end else if (pick < 55) begin
        act = ACT_BELOW;
      end else if (pick < 96) begin
        act = ACT_BETWEEN;
      end else begin
        act = ACT_UNUSED;
      end
      lo = pick_bound();
      hi = pick_bound();
      if (act == ACT_BETWEEN && $urandom_range(0, 3) == 0) begin
        hi = lo + 32'($urandom_range(0, 3));
      end
      send_item(act, lo, hi);
    end
    no_idle = 1'b0;
    wait_drained();
  endtask

  initial begin
    load_seed('0);
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_state();
    test_special_cases();
    test_seed_extremes();
    write_seed($urandom());
    test_random_traffic(200);
    write_seed($urandom());
    test_random_traffic(150);
    write_seed($urandom());
    test_random_traffic(150);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Sent raw %0d, below %0d, between %0d, unused %0d items over %0d seed writes",
             act_count[ACT_RAW], act_count[ACT_BELOW], act_count[ACT_BETWEEN],
             act_count[ACT_UNUSED], seed_writes);
    $display("Checked %0d results, %0d mismatches", results_checked, err_count);
    if (err_count == 0 && pending_values.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
